// File: design/rsawd_pkg.sv
// shared types and constants for the reflect sensor average and wall detect block
// no dependencies
`default_nettype none

package rsawd_pkg;

    localparam int DATA_W         = 12;
    localparam int DIFF_W         = 13;
    localparam int WINDOW_DEFAULT = 3;
    localparam int NUM_REGS       = 8;
    localparam int CFG_IDX_W      = 3;

    localparam logic GROUP_SIDE  = 1'b0;
    localparam logic GROUP_FRONT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LEFT_LIMIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_RIGHT_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_LEFT_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_RIGHT_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LEFT_REF_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_RIGHT_REF_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_LEFT_REF_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_RIGHT_REF_LIMIT = 3'd7;

    typedef struct packed {
        logic signed [DIFF_W-1:0] left;
        logic signed [DIFF_W-1:0] right;
    } diff_pair_t;

    typedef struct packed {
        logic shift;
        logic group;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/rsawd_cell.sv
// one cell of the difference history chain: holds one side entry and one front entry
// depends on rsawd_pkg
`default_nettype none

module rsawd_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rsawd_pkg::cell_ctl_t     ctl,
    input  wire rsawd_pkg::diff_pair_t    side_in,
    input  wire rsawd_pkg::diff_pair_t    front_in,
    output rsawd_pkg::diff_pair_t    side_out,
    output rsawd_pkg::diff_pair_t    front_out
);

    rsawd_pkg::diff_pair_t side_reg;
    rsawd_pkg::diff_pair_t front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= '0;
            front_reg <= '0;
        end
        else if (ctl.shift)
        begin
            if (ctl.group == rsawd_pkg::GROUP_FRONT)
            begin
                front_reg <= front_in;
            end
            else
            begin
                side_reg <= side_in;
            end
        end
    end

    assign side_out  = side_reg;
    assign front_out = front_reg;

endmodule

`default_nettype wire

// File: design/reflect_sensor_average_wall_detect_unit.sv
// top level: difference chain, running sums, constant divide and wall compare
// depends on rsawd_pkg and rsawd_cell
//
//   channel   valid      stall      payload
//   input     in_valid   in_stall   group, left_dark, left_bright, right_dark, right_bright
//   output    out_valid  out_stall  group_out, averages, wall flags
//   config    cfg_we     -          cfg_index, cfg_data
//
// one request per cycle while in_stall is low; a result passes the stage 1, stage 2 and output registers
// pipeline: running sum update, reciprocal multiply, sign fix and compare
// after reset all history entries and limits are zero
// out_stall holds the pipeline; stages drain into empty slots ahead of them
`default_nettype none

module reflect_sensor_average_wall_detect_unit #(
    parameter int WINDOW = rsawd_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  group,
    input  wire logic        [rsawd_pkg::DATA_W-1:0]   left_dark,
    input  wire logic        [rsawd_pkg::DATA_W-1:0]   left_bright,
    input  wire logic        [rsawd_pkg::DATA_W-1:0]   right_dark,
    input  wire logic        [rsawd_pkg::DATA_W-1:0]   right_bright,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       group_out,
    output logic signed      [rsawd_pkg::DIFF_W-1:0]   left_average,
    output logic signed      [rsawd_pkg::DIFF_W-1:0]   right_average,
    output logic                                       left_wall,
    output logic                                       right_wall,
    output logic                                       front_wall,
    output logic                                       left_ref_wall,
    output logic                                       right_ref_wall,
    output logic                                       front_ref_wall,
    input  wire logic                                  cfg_we,
    input  wire logic        [rsawd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [rsawd_pkg::DATA_W-1:0]   cfg_data
);

    localparam int DATA_W  = rsawd_pkg::DATA_W;
    localparam int DIFF_W  = rsawd_pkg::DIFF_W;
    localparam int SUM_W   = DIFF_W + $clog2(WINDOW);
    localparam int ABS_W   = SUM_W - 1;
    localparam int SHIFT   = ABS_W + $clog2(WINDOW);
    localparam longint RECIP = ((longint'(1) << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RECIP_W = ABS_W + 1;
    localparam int PROD_W  = ABS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP[RECIP_W-1:0];

    // limit registers
    logic [DATA_W-1:0] cfg_reg [rsawd_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rsawd_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // pipeline flow
    logic v1_reg, v2_reg, out_valid_reg;
    logic free1, free2, free3, accept;

    assign free3    = !out_valid_reg || !out_stall;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_stall = !free1;
    assign accept   = in_valid && free1;

    // new differences
    rsawd_pkg::diff_pair_t new_diff;
    assign new_diff.left  = $signed({1'b0, left_bright}) - $signed({1'b0, left_dark});
    assign new_diff.right = $signed({1'b0, right_bright}) - $signed({1'b0, right_dark});

    // history chain
    rsawd_pkg::cell_ctl_t  ctl;
    rsawd_pkg::diff_pair_t side_tap  [WINDOW];
    rsawd_pkg::diff_pair_t front_tap [WINDOW];

    assign ctl.shift = accept;
    assign ctl.group = group;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++)
        begin : g_cell
            rsawd_pkg::diff_pair_t side_feed;
            rsawd_pkg::diff_pair_t front_feed;
            if (g == 0)
            begin : g_head
                assign side_feed  = new_diff;
                assign front_feed = new_diff;
            end
            else
            begin : g_link
                assign side_feed  = side_tap[g-1];
                assign front_feed = front_tap[g-1];
            end
            rsawd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .side_in   (side_feed),
                .front_in  (front_feed),
                .side_out  (side_tap[g]),
                .front_out (front_tap[g])
            );
        end
    endgenerate

    // running sums
    logic signed [SUM_W-1:0] side_l_sum_reg, side_r_sum_reg;
    logic signed [SUM_W-1:0] front_l_sum_reg, front_r_sum_reg;
    logic signed [SUM_W-1:0] old_l_sum, old_r_sum;
    logic signed [SUM_W-1:0] l_sum_next, r_sum_next;
    rsawd_pkg::diff_pair_t   oldest;

    always_comb
    begin
        if (group == rsawd_pkg::GROUP_FRONT)
        begin
            old_l_sum = front_l_sum_reg;
            old_r_sum = front_r_sum_reg;
            oldest    = front_tap[WINDOW-1];
        end
        else
        begin
            old_l_sum = side_l_sum_reg;
            old_r_sum = side_r_sum_reg;
            oldest    = side_tap[WINDOW-1];
        end
        l_sum_next = old_l_sum + SUM_W'(new_diff.left) - SUM_W'(oldest.left);
        r_sum_next = old_r_sum + SUM_W'(new_diff.right) - SUM_W'(oldest.right);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_l_sum_reg  <= '0;
            side_r_sum_reg  <= '0;
            front_l_sum_reg <= '0;
            front_r_sum_reg <= '0;
        end
        else if (accept)
        begin
            if (group == rsawd_pkg::GROUP_FRONT)
            begin
                front_l_sum_reg <= l_sum_next;
                front_r_sum_reg <= r_sum_next;
            end
            else
            begin
                side_l_sum_reg <= l_sum_next;
                side_r_sum_reg <= r_sum_next;
            end
        end
    end

    // stage 1: magnitude and sign
    logic [SUM_W-1:0] l_mag_full, r_mag_full;
    logic [ABS_W-1:0] l_abs1_reg, r_abs1_reg;
    logic             l_neg1_reg, r_neg1_reg, grp1_reg;

    assign l_mag_full = l_sum_next[SUM_W-1] ? SUM_W'(-l_sum_next) : SUM_W'(l_sum_next);
    assign r_mag_full = r_sum_next[SUM_W-1] ? SUM_W'(-r_sum_next) : SUM_W'(r_sum_next);

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            l_abs1_reg <= l_mag_full[ABS_W-1:0];
            r_abs1_reg <= r_mag_full[ABS_W-1:0];
            l_neg1_reg <= l_sum_next[SUM_W-1];
            r_neg1_reg <= r_sum_next[SUM_W-1];
            grp1_reg   <= group;
        end
    end

    // stage 2: reciprocal multiply
    logic [PROD_W-1:0] l_prod2_reg, r_prod2_reg;
    logic              l_neg2_reg, r_neg2_reg, grp2_reg;

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            l_prod2_reg <= PROD_W'(l_abs1_reg) * PROD_W'(RECIP_K);
            r_prod2_reg <= PROD_W'(r_abs1_reg) * PROD_W'(RECIP_K);
            l_neg2_reg  <= l_neg1_reg;
            r_neg2_reg  <= r_neg1_reg;
            grp2_reg    <= grp1_reg;
        end
    end

    // stage 3: sign, compare, output register
    logic [DATA_W-1:0]        l_quot, r_quot;
    logic signed [DIFF_W-1:0] l_avg, r_avg;
    logic [DATA_W-1:0]        l_lim, r_lim, l_ref, r_ref;
    logic                     lw, rw, lrw, rrw;

    assign l_quot = l_prod2_reg[SHIFT +: DATA_W];
    assign r_quot = r_prod2_reg[SHIFT +: DATA_W];
    assign l_avg  = l_neg2_reg ? -$signed({1'b0, l_quot}) : $signed({1'b0, l_quot});
    assign r_avg  = r_neg2_reg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});

    always_comb
    begin
        if (grp2_reg == rsawd_pkg::GROUP_FRONT)
        begin
            l_lim = cfg_reg[rsawd_pkg::REG_FRONT_LEFT_LIMIT];
            r_lim = cfg_reg[rsawd_pkg::REG_FRONT_RIGHT_LIMIT];
            l_ref = cfg_reg[rsawd_pkg::REG_FRONT_LEFT_REF_LIMIT];
            r_ref = cfg_reg[rsawd_pkg::REG_FRONT_RIGHT_REF_LIMIT];
        end
        else
        begin
            l_lim = cfg_reg[rsawd_pkg::REG_SIDE_LEFT_LIMIT];
            r_lim = cfg_reg[rsawd_pkg::REG_SIDE_RIGHT_LIMIT];
            l_ref = cfg_reg[rsawd_pkg::REG_SIDE_LEFT_REF_LIMIT];
            r_ref = cfg_reg[rsawd_pkg::REG_SIDE_RIGHT_REF_LIMIT];
        end
        lw  = l_avg > $signed({1'b0, l_lim});
        rw  = r_avg > $signed({1'b0, r_lim});
        lrw = l_avg > $signed({1'b0, l_ref});
        rrw = r_avg > $signed({1'b0, r_ref});
    end

    logic                     grp_out_reg;
    logic signed [DIFF_W-1:0] l_avg_reg, r_avg_reg;
    logic                     lw_reg, rw_reg, fw_reg, lrw_reg, rrw_reg, frw_reg;

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            grp_out_reg <= grp2_reg;
            l_avg_reg   <= l_avg;
            r_avg_reg   <= r_avg;
            lw_reg      <= lw;
            rw_reg      <= rw;
            fw_reg      <= (grp2_reg == rsawd_pkg::GROUP_FRONT) && (lw || rw);
            lrw_reg     <= lrw;
            rrw_reg     <= rrw;
            frw_reg     <= (grp2_reg == rsawd_pkg::GROUP_FRONT) && (lrw || rrw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= in_valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign group_out      = grp_out_reg;
    assign left_average   = l_avg_reg;
    assign right_average  = r_avg_reg;
    assign left_wall      = lw_reg;
    assign right_wall     = rw_reg;
    assign front_wall     = fw_reg;
    assign left_ref_wall  = lrw_reg;
    assign right_ref_wall = rrw_reg;
    assign front_ref_wall = frw_reg;

endmodule

`default_nettype wire

// File: design/rsawd_checker.sv
// port-level checks for the reflect sensor average and wall detect block
// depends on rsawd_pkg; bound to reflect_sensor_average_wall_detect_unit
`default_nettype none

module rsawd_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  out_valid,
    input wire logic                                  out_stall,
    input wire logic                                  group_out,
    input wire logic signed [rsawd_pkg::DIFF_W-1:0]   left_average,
    input wire logic                                  left_wall,
    input wire logic                                  right_wall,
    input wire logic                                  front_wall,
    input wire logic                                  left_ref_wall,
    input wire logic                                  right_ref_wall,
    input wire logic                                  front_ref_wall
);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_average) && $stable(group_out))
        else $error("stalled result changed");

    a_side_no_front: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && group_out == rsawd_pkg::GROUP_SIDE |-> !front_wall && !front_ref_wall)
        else $error("front flags set on side result");

    a_front_or: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && group_out == rsawd_pkg::GROUP_FRONT
        |-> front_wall == (left_wall || right_wall)
            && front_ref_wall == (left_ref_wall || right_ref_wall))
        else $error("front flags disagree with side flags");

    a_negative_no_wall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && left_average[rsawd_pkg::DIFF_W-1] |-> !left_wall && !left_ref_wall)
        else $error("wall on negative average");

endmodule

bind reflect_sensor_average_wall_detect_unit rsawd_checker u_rsawd_checker (.*);

`default_nettype wire

// File: sim/wall_detect_monitor.sv
// monitor for reflect_sensor_average_wall_detect_unit: tracks limit writes, predicts averages
// and wall flags per accepted request, compares each accepted result in order
// depends on rsawd_pkg
module wall_detect_monitor #(
    parameter int WINDOW = rsawd_pkg::WINDOW_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                group,
    input  logic [rsawd_pkg::DATA_W-1:0]        left_dark,
    input  logic [rsawd_pkg::DATA_W-1:0]        left_bright,
    input  logic [rsawd_pkg::DATA_W-1:0]        right_dark,
    input  logic [rsawd_pkg::DATA_W-1:0]        right_bright,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                group_out,
    input  logic signed [rsawd_pkg::DIFF_W-1:0] left_average,
    input  logic signed [rsawd_pkg::DIFF_W-1:0] right_average,
    input  logic                                left_wall,
    input  logic                                right_wall,
    input  logic                                front_wall,
    input  logic                                left_ref_wall,
    input  logic                                right_ref_wall,
    input  logic                                front_ref_wall,
    input  logic                                cfg_we,
    input  logic [rsawd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsawd_pkg::DATA_W-1:0]        cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                                grp;
        logic signed [rsawd_pkg::DIFF_W-1:0] lavg;
        logic signed [rsawd_pkg::DIFF_W-1:0] ravg;
        logic                                lw;
        logic                                rw;
        logic                                fw;
        logic                                lrw;
        logic                                rrw;
        logic                                frw;
    } wall_result_t;

    logic [rsawd_pkg::DATA_W-1:0]        limit_reg [rsawd_pkg::NUM_REGS];
    logic signed [rsawd_pkg::DIFF_W-1:0] left_hist [2][WINDOW];
    logic signed [rsawd_pkg::DIFF_W-1:0] right_hist[2][WINDOW];
    int                                  hist_slot [2];
    wall_result_t                        expected_walls[$];

    function automatic wall_result_t predict_walls(input logic grp,
                                                   input logic [rsawd_pkg::DATA_W-1:0] ld,
                                                   input logic [rsawd_pkg::DATA_W-1:0] lb,
                                                   input logic [rsawd_pkg::DATA_W-1:0] rd,
                                                   input logic [rsawd_pkg::DATA_W-1:0] rb);
        wall_result_t res;
        int g;
        int lsum;
        int rsum;
        int lavg;
        int ravg;
        int llim;
        int rlim;
        int lref;
        int rref;
        g    = int'(grp);
        lsum = 0;
        rsum = 0;
        left_hist[g][hist_slot[g]]  = rsawd_pkg::DIFF_W'(int'(lb) - int'(ld));
        right_hist[g][hist_slot[g]] = rsawd_pkg::DIFF_W'(int'(rb) - int'(rd));
        hist_slot[g] = (hist_slot[g] >= WINDOW - 1) ? 0 : hist_slot[g] + 1;
        for (int i = 0; i < WINDOW; i++)
        begin
            lsum += int'(left_hist[g][i]);
            rsum += int'(right_hist[g][i]);
        end
        lavg = lsum / WINDOW;
        ravg = rsum / WINDOW;
        if (grp == rsawd_pkg::GROUP_FRONT)
        begin
            llim = int'(limit_reg[rsawd_pkg::REG_FRONT_LEFT_LIMIT]);
            rlim = int'(limit_reg[rsawd_pkg::REG_FRONT_RIGHT_LIMIT]);
            lref = int'(limit_reg[rsawd_pkg::REG_FRONT_LEFT_REF_LIMIT]);
            rref = int'(limit_reg[rsawd_pkg::REG_FRONT_RIGHT_REF_LIMIT]);
        end
        else
        begin
            llim = int'(limit_reg[rsawd_pkg::REG_SIDE_LEFT_LIMIT]);
            rlim = int'(limit_reg[rsawd_pkg::REG_SIDE_RIGHT_LIMIT]);
            lref = int'(limit_reg[rsawd_pkg::REG_SIDE_LEFT_REF_LIMIT]);
            rref = int'(limit_reg[rsawd_pkg::REG_SIDE_RIGHT_REF_LIMIT]);
        end
        res.grp  = grp;
        res.lavg = rsawd_pkg::DIFF_W'(lavg);
        res.ravg = rsawd_pkg::DIFF_W'(ravg);
        res.lw   = lavg > llim;
        res.rw   = ravg > rlim;
        res.lrw  = lavg > lref;
        res.rrw  = ravg > rref;
        res.fw   = (grp == rsawd_pkg::GROUP_FRONT) && (res.lw || res.rw);
        res.frw  = (grp == rsawd_pkg::GROUP_FRONT) && (res.lrw || res.rrw);
        return res;
    endfunction

    function automatic void compare_field(input string name, input int exp_val,
                                          input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wall_result_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < rsawd_pkg::NUM_REGS; i++)
                limit_reg[i] = '0;
            for (int g = 0; g < 2; g++)
            begin
                hist_slot[g] = 0;
                for (int i = 0; i < WINDOW; i++)
                begin
                    left_hist[g][i]  = '0;
                    right_hist[g][i] = '0;
                end
            end
            expected_walls.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                limit_reg[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
                expected_walls.push_back(predict_walls(group, left_dark, left_bright,
                                                       right_dark, right_bright));
            if (out_valid && !out_stall)
            begin
                if (expected_walls.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_walls.pop_front();
                    compare_field("group_out", int'(exp_res.grp), int'(group_out));
                    compare_field("left_average", int'(exp_res.lavg), int'(left_average));
                    compare_field("right_average", int'(exp_res.ravg), int'(right_average));
                    compare_field("left_wall", int'(exp_res.lw), int'(left_wall));
                    compare_field("right_wall", int'(exp_res.rw), int'(right_wall));
                    compare_field("front_wall", int'(exp_res.fw), int'(front_wall));
                    compare_field("left_ref_wall", int'(exp_res.lrw), int'(left_ref_wall));
                    compare_field("right_ref_wall", int'(exp_res.rrw), int'(right_ref_wall));
                    compare_field("front_ref_wall", int'(exp_res.frw), int'(front_ref_wall));
                end
            end
            pending <= expected_walls.size();
        end
    end

endmodule

// File: sim/testbench.sv
// top of the wall detect simulation: clock, reset, request and limit stimulus, verdict
// depends on rsawd_pkg, reflect_sensor_average_wall_detect_unit and wall_detect_monitor
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 3;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic                                in_stall;
    logic                                group        = rsawd_pkg::GROUP_SIDE;
    logic [rsawd_pkg::DATA_W-1:0]        left_dark    = '0;
    logic [rsawd_pkg::DATA_W-1:0]        left_bright  = '0;
    logic [rsawd_pkg::DATA_W-1:0]        right_dark   = '0;
    logic [rsawd_pkg::DATA_W-1:0]        right_bright = '0;
    logic                                out_valid;
    logic                                out_stall    = 1'b0;
    logic                                group_out;
    logic signed [rsawd_pkg::DIFF_W-1:0] left_average;
    logic signed [rsawd_pkg::DIFF_W-1:0] right_average;
    logic                                left_wall;
    logic                                right_wall;
    logic                                front_wall;
    logic                                left_ref_wall;
    logic                                right_ref_wall;
    logic                                front_ref_wall;
    logic                                cfg_we       = 1'b0;
    logic [rsawd_pkg::CFG_IDX_W-1:0]     cfg_index    = '0;
    logic [rsawd_pkg::DATA_W-1:0]        cfg_data     = '0;
    int                                  fail_count;
    int                                  pending;

    int                                  send_idle_pct = 0;
    int                                  stall_pct     = 0;
    int                                  hold_cycles   = 0;
    int                                  cycle_count   = 0;
    logic [rsawd_pkg::DATA_W-1:0]        limits [rsawd_pkg::NUM_REGS];

    reflect_sensor_average_wall_detect_unit u_top (.*);

    wall_detect_monitor u_monitor (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long hold-off counts down here; otherwise random stall
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic offer(input logic grp, input logic [rsawd_pkg::DATA_W-1:0] ld,
                         input logic [rsawd_pkg::DATA_W-1:0] lb,
                         input logic [rsawd_pkg::DATA_W-1:0] rd,
                         input logic [rsawd_pkg::DATA_W-1:0] rb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        group        <= grp;
        left_dark    <= ld;
        left_bright  <= lb;
        right_dark   <= rd;
        right_bright <= rb;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic offer_random();
        int kind;
        logic [rsawd_pkg::DATA_W-1:0] ld;
        logic [rsawd_pkg::DATA_W-1:0] lb;
        logic [rsawd_pkg::DATA_W-1:0] rd;
        logic [rsawd_pkg::DATA_W-1:0] rb;
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            // reflective surface: low ambient, strong return
            ld = rsawd_pkg::DATA_W'($urandom_range(511));
            lb = rsawd_pkg::DATA_W'($urandom);
            rd = rsawd_pkg::DATA_W'($urandom_range(511));
            rb = rsawd_pkg::DATA_W'($urandom);
        end
        else if (kind < 75)
        begin
            ld = rsawd_pkg::DATA_W'($urandom);
            lb = rsawd_pkg::DATA_W'($urandom);
            rd = rsawd_pkg::DATA_W'($urandom);
            rb = rsawd_pkg::DATA_W'($urandom);
        end
        else if (kind < 90)
        begin
            // bright drawn from the low range, dark from the full range
            ld = rsawd_pkg::DATA_W'($urandom);
            lb = rsawd_pkg::DATA_W'($urandom_range(511));
            rd = rsawd_pkg::DATA_W'($urandom);
            rb = rsawd_pkg::DATA_W'($urandom_range(511));
        end
        else
        begin
            ld = $urandom_range(1) ? '1 : '0;
            lb = $urandom_range(1) ? '1 : '0;
            rd = $urandom_range(1) ? '1 : '0;
            rb = $urandom_range(1) ? '1 : '0;
        end
        offer(1'($urandom_range(1)), ld, lb, rd, rb);
    endtask

    task automatic offer_burst(input int count);
        repeat (count)
            offer_random();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 1)
            @(posedge clk);
    endtask

    task automatic load_limits();
        for (int i = 0; i < rsawd_pkg::NUM_REGS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= rsawd_pkg::CFG_IDX_W'(i);
            cfg_data  <= limits[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_limits();
        for (int i = 0; i < rsawd_pkg::NUM_REGS; i++)
            limits[i] = rsawd_pkg::DATA_W'($urandom_range(1500));
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        limits[rsawd_pkg::REG_SIDE_LEFT_LIMIT]       = 12'd100;
        limits[rsawd_pkg::REG_SIDE_RIGHT_LIMIT]      = 12'd200;
        limits[rsawd_pkg::REG_FRONT_LEFT_LIMIT]      = 12'd300;
        limits[rsawd_pkg::REG_FRONT_RIGHT_LIMIT]     = 12'd400;
        limits[rsawd_pkg::REG_SIDE_LEFT_REF_LIMIT]   = 12'd99;
        limits[rsawd_pkg::REG_SIDE_RIGHT_REF_LIMIT]  = 12'd201;
        limits[rsawd_pkg::REG_FRONT_LEFT_REF_LIMIT]  = 12'd1364;
        limits[rsawd_pkg::REG_FRONT_RIGHT_REF_LIMIT] = 12'd0;
        load_limits();

        // averages land on and around the limits
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd300, 12'd0, 12'd600);
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd300, 12'd0, 12'd600);
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd300, 12'd0, 12'd600);
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd301, 12'd0, 12'd0);
        // negative extremes, then positive extremes past the wrap
        offer(rsawd_pkg::GROUP_FRONT, 12'd4095, 12'd0, 12'd4095, 12'd0);
        offer(rsawd_pkg::GROUP_FRONT, 12'd4095, 12'd0, 12'd4095, 12'd0);
        offer(rsawd_pkg::GROUP_FRONT, 12'd4095, 12'd0, 12'd4095, 12'd0);
        offer(rsawd_pkg::GROUP_FRONT, 12'd0, 12'd4095, 12'd0, 12'd4095);
        offer(rsawd_pkg::GROUP_FRONT, 12'd0, 12'd4095, 12'd0, 12'd4095);
        offer(rsawd_pkg::GROUP_FRONT, 12'd0, 12'd4095, 12'd0, 12'd4095);
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd4095, 12'd0, 12'd4095);
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd4095, 12'd0, 12'd4095);
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd4095, 12'd0, 12'd4095);
        // small negative sums truncate toward zero
        offer(rsawd_pkg::GROUP_SIDE, 12'd1, 12'd0, 12'd2, 12'd0);
        offer(rsawd_pkg::GROUP_SIDE, 12'd4095, 12'd4095, 12'd2, 12'd0);
        offer(rsawd_pkg::GROUP_SIDE, 12'd0, 12'd0, 12'd0, 12'd0);
        offer(rsawd_pkg::GROUP_FRONT, 12'd1365, 12'd0, 12'd0, 12'd1);
        offer(rsawd_pkg::GROUP_FRONT, 12'd2730, 12'd2729, 12'd0, 12'd0);
        offer(rsawd_pkg::GROUP_FRONT, 12'd2730, 12'd2730, 12'd4095, 12'd4095);
        drain();

        for (int i = 0; i < rsawd_pkg::NUM_REGS; i++)
            limits[i] = '1;
        load_limits();
        offer_burst(150);
        drain();

        random_limits();
        load_limits();
        send_idle_pct = 80;
        offer_burst(150);
        drain();

        for (int i = 0; i < rsawd_pkg::NUM_REGS; i++)
            limits[i] = '0;
        load_limits();
        send_idle_pct = 0;
        stall_pct     = 80;
        offer_burst(150);
        drain();

        random_limits();
        load_limits();
        stall_pct   = 0;
        hold_cycles = 60;
        offer_burst(40);
        send_idle_pct = 16;
        stall_pct     = 16;
        offer_burst(150);
        drain();

        random_limits();
        load_limits();
        send_idle_pct = 0;
        stall_pct     = 0;
        offer_burst(150);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
